FILE: rtl/core/qpa_pkg.sv
// Shared constants, types and sign-table helpers for the quaternion product accumulator.
package qpa_pkg;

    localparam int NUM_COMP = 4;

    typedef logic [1:0] comp_idx_t;

    // Valid and end-of-batch flags that move down the pipeline with the data.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

    // Gradient component paired with activation component i in result k.
    function automatic comp_idx_t pair_idx(input comp_idx_t k, input comp_idx_t i);
        return k ^ i;
    endfunction

    // True where term i of result k enters with a minus sign.
    function automatic logic term_negated(input comp_idx_t k, input comp_idx_t i);
        logic [NUM_COMP-1:0] mask;
        case (k)
            2'd0:    mask = 4'b0000;
            2'd1:    mask = 4'b0110;
            2'd2:    mask = 4'b1100;
            2'd3:    mask = 4'b1010;
            default: mask = 4'b0000;
        endcase
        return mask[i];
    endfunction

endpackage

FILE: rtl/core/qpa_channels.sv
// Valid/ready channel interfaces for the input quaternion pairs and the output sums.
interface qpa_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] act_comp0;
    logic signed [SAMPLE_BITS-1:0] act_comp1;
    logic signed [SAMPLE_BITS-1:0] act_comp2;
    logic signed [SAMPLE_BITS-1:0] act_comp3;
    logic signed [SAMPLE_BITS-1:0] grad_comp0;
    logic signed [SAMPLE_BITS-1:0] grad_comp1;
    logic signed [SAMPLE_BITS-1:0] grad_comp2;
    logic signed [SAMPLE_BITS-1:0] grad_comp3;
    logic                          last_in_batch;

    modport source (
        output valid, act_comp0, act_comp1, act_comp2, act_comp3,
        output grad_comp0, grad_comp1, grad_comp2, grad_comp3, last_in_batch,
        input  ready
    );
    modport sink (
        input  valid, act_comp0, act_comp1, act_comp2, act_comp3,
        input  grad_comp0, grad_comp1, grad_comp2, grad_comp3, last_in_batch,
        output ready
    );
endinterface

interface qpa_out_if #(
    parameter int ACC_BITS = 56
);
    logic                       valid;
    logic                       ready;
    logic signed [ACC_BITS-1:0] sum_comp0;
    logic signed [ACC_BITS-1:0] sum_comp1;
    logic signed [ACC_BITS-1:0] sum_comp2;
    logic signed [ACC_BITS-1:0] sum_comp3;

    modport source (
        output valid, sum_comp0, sum_comp1, sum_comp2, sum_comp3,
        input  ready
    );
    modport sink (
        input  valid, sum_comp0, sum_comp1, sum_comp2, sum_comp3,
        output ready
    );
endinterface

FILE: rtl/core/qpa_products.sv
// Sixteen-multiplier array forming every activation-by-gradient component product.
module qpa_products #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  qpa_pkg::stage_ctl_t             ctl_in,
    input  logic signed [SAMPLE_BITS-1:0]   u_op [qpa_pkg::NUM_COMP],
    input  logic signed [SAMPLE_BITS-1:0]   v_op [qpa_pkg::NUM_COMP],
    output qpa_pkg::stage_ctl_t             ctl_out,
    output logic signed [2*SAMPLE_BITS-1:0] prod [qpa_pkg::NUM_COMP][qpa_pkg::NUM_COMP]
);

    localparam int PW = 2 * SAMPLE_BITS;

    qpa_pkg::stage_ctl_t     ctl_reg;
    logic signed [PW-1:0]    prod_reg  [qpa_pkg::NUM_COMP][qpa_pkg::NUM_COMP];
    logic signed [PW-1:0]    prod_next [qpa_pkg::NUM_COMP][qpa_pkg::NUM_COMP];

    // prod[k][i] = u[i] * v[k ^ i]
    for (genvar k = 0; k < qpa_pkg::NUM_COMP; k++)
    begin : g_row
        for (genvar i = 0; i < qpa_pkg::NUM_COMP; i++)
        begin : g_col
            assign prod_next[k][i] = PW'(u_op[i])
                                   * PW'(v_op[qpa_pkg::pair_idx(2'(k), 2'(i))]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign prod    = prod_reg;

endmodule

FILE: rtl/core/qpa_accum.sv
// Signed term reduction, saturating accumulators and the result register.
module qpa_accum #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 56
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  qpa_pkg::stage_ctl_t             ctl_in,
    input  logic signed [2*SAMPLE_BITS-1:0] prod [qpa_pkg::NUM_COMP][qpa_pkg::NUM_COMP],
    output logic                            res_valid,
    output logic signed [ACC_BITS-1:0]      res_sum [qpa_pkg::NUM_COMP]
);

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int TW = PW + 2;
    localparam int SW = ((ACC_BITS > TW) ? ACC_BITS : TW) + 1;
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    qpa_pkg::stage_ctl_t        ctl_reg;
    logic signed [TW-1:0]       term_reg  [qpa_pkg::NUM_COMP];
    logic signed [TW-1:0]       term_next [qpa_pkg::NUM_COMP];
    logic signed [ACC_BITS-1:0] acc_reg   [qpa_pkg::NUM_COMP];
    logic signed [ACC_BITS-1:0] sat_next  [qpa_pkg::NUM_COMP];
    logic signed [ACC_BITS-1:0] res_reg   [qpa_pkg::NUM_COMP];
    logic                       res_valid_reg;

    // Reduce four signed products into one term per result component.
    always_comb
    begin
        for (int k = 0; k < qpa_pkg::NUM_COMP; k++)
        begin
            term_next[k] = '0;
            for (int i = 0; i < qpa_pkg::NUM_COMP; i++)
            begin
                if (qpa_pkg::term_negated(2'(k), 2'(i)))
                    term_next[k] = term_next[k] - {{2{prod[k][i][PW-1]}}, prod[k][i]};
                else
                    term_next[k] = term_next[k] + {{2{prod[k][i][PW-1]}}, prod[k][i]};
            end
        end
    end

    // Exact add, then clamp once to the accumulator range.
    for (genvar k = 0; k < qpa_pkg::NUM_COMP; k++)
    begin : g_sat
        logic signed [SW-1:0]     exact;
        logic [SW-ACC_BITS:0]     upper;

        assign exact = {{(SW-ACC_BITS){acc_reg[k][ACC_BITS-1]}}, acc_reg[k]}
                     + {{(SW-TW){term_reg[k][TW-1]}}, term_reg[k]};
        assign upper = exact[SW-1:ACC_BITS-1];
        assign sat_next[k] = ((upper == '0) || (upper == '1)) ? exact[ACC_BITS-1:0]
                           : (exact[SW-1] ? ACC_MIN : ACC_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < qpa_pkg::NUM_COMP; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            ctl_reg       <= ctl_in;
            res_valid_reg <= ctl_reg.valid && ctl_reg.last;
            if (ctl_reg.valid)
            begin
                for (int k = 0; k < qpa_pkg::NUM_COMP; k++)
                begin
                    acc_reg[k] <= ctl_reg.last ? '0 : sat_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            term_reg <= term_next;
            if (ctl_reg.valid && ctl_reg.last)
            begin
                res_reg <= sat_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_sum   = res_reg;

endmodule

FILE: rtl/core/quaternion_product_accumulator.sv
// Top level: batch accumulator of quaternion conjugate products with saturating sums.
//
// Usage:
//   in_ch transfers one quaternion pair (act_comp0..3, grad_comp0..3) plus
//   last_in_batch. Every transfer adds its four product terms into four
//   running sums. A transfer with last_in_batch set closes the batch: the
//   sums including that pair leave on out_ch as one transfer and the sums
//   restart from zero.
//   cfg_we/cfg_wdata write transpose_mode (bit 0); write it only while idle.
//   Throughput: one transfer per clock while out_ch is not stalled, set by
//   the sixteen-multiplier array and the accumulate loop per component.
//   The sums of the closing transfer reach out_ch through the input register
//   (loaded at the transfer edge), then the product register, the term
//   register and the result register, in that order.
//   Reset clears the sums, transpose_mode and all valid flags.
//   When out_ch stalls with a result pending, the whole pipeline holds and
//   in_ch.ready drops until the result is taken.
module quaternion_product_accumulator #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 56
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    qpa_in_if.sink      in_ch,
    qpa_out_if.source   out_ch
);

    logic                          transpose_reg;
    logic                          advance;
    qpa_pkg::stage_ctl_t           in_ctl_reg;
    qpa_pkg::stage_ctl_t           prod_ctl;
    logic signed [SAMPLE_BITS-1:0] u_reg [qpa_pkg::NUM_COMP];
    logic signed [SAMPLE_BITS-1:0] v_reg [qpa_pkg::NUM_COMP];
    logic signed [SAMPLE_BITS-1:0] act_in  [qpa_pkg::NUM_COMP];
    logic signed [SAMPLE_BITS-1:0] grad_in [qpa_pkg::NUM_COMP];
    logic signed [2*SAMPLE_BITS-1:0] prod [qpa_pkg::NUM_COMP][qpa_pkg::NUM_COMP];
    logic                          res_valid;
    logic signed [ACC_BITS-1:0]    res_sum [qpa_pkg::NUM_COMP];

    // Hold every stage while a finished result waits on a stalled receiver.
    assign advance     = !(res_valid && !out_ch.ready);
    assign in_ch.ready = advance;

    assign act_in[0]  = in_ch.act_comp0;
    assign act_in[1]  = in_ch.act_comp1;
    assign act_in[2]  = in_ch.act_comp2;
    assign act_in[3]  = in_ch.act_comp3;
    assign grad_in[0] = in_ch.grad_comp0;
    assign grad_in[1] = in_ch.grad_comp1;
    assign grad_in[2] = in_ch.grad_comp2;
    assign grad_in[3] = in_ch.grad_comp3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transpose_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            transpose_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else if (advance)
        begin
            in_ctl_reg.valid <= in_ch.valid;
            in_ctl_reg.last  <= in_ch.last_in_batch;
        end
    end

    // Swap the operands on the way in when transpose mode is set.
    always_ff @(posedge clk)
    begin
        if (advance && in_ch.valid)
        begin
            for (int i = 0; i < qpa_pkg::NUM_COMP; i++)
            begin
                u_reg[i] <= transpose_reg ? grad_in[i] : act_in[i];
                v_reg[i] <= transpose_reg ? act_in[i]  : grad_in[i];
            end
        end
    end

    qpa_products #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_products (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ctl_in  (in_ctl_reg),
        .u_op    (u_reg),
        .v_op    (v_reg),
        .ctl_out (prod_ctl),
        .prod    (prod)
    );

    qpa_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl_in    (prod_ctl),
        .prod      (prod),
        .res_valid (res_valid),
        .res_sum   (res_sum)
    );

    assign out_ch.valid     = res_valid;
    assign out_ch.sum_comp0 = res_sum[0];
    assign out_ch.sum_comp1 = res_sum[1];
    assign out_ch.sum_comp2 = res_sum[2];
    assign out_ch.sum_comp3 = res_sum[3];

endmodule
